// ----- hdl/sbt_pkg.sv -----
package sbt_pkg;

    // Result token kinds
    localparam logic [3:0] K_BYTE    = 4'd0;
    localparam logic [3:0] K_NUMBER  = 4'd1;
    localparam logic [3:0] K_SYMBOL  = 4'd2;
    localparam logic [3:0] K_LPAR    = 4'd3;
    localparam logic [3:0] K_RPAR    = 4'd4;
    localparam logic [3:0] K_DOT     = 4'd5;
    localparam logic [3:0] K_QUOTE   = 4'd6;
    localparam logic [3:0] K_QUASI   = 4'd7;
    localparam logic [3:0] K_UNQUOTE = 4'd8;
    localparam logic [3:0] K_SYM     = 4'd9;
    localparam logic [3:0] K_NUM     = 4'd10;
    localparam logic [3:0] K_ATM     = 4'd11;
    localparam logic [3:0] K_EXP     = 4'd12;
    localparam logic [3:0] K_HOT     = 4'd13;
    localparam logic [3:0] K_EOF     = 4'd14;
    localparam logic [3:0] K_NONE    = 4'd15;

    localparam int MAX_ATOM_LEN_DEFAULT = 255;

    // Character codes
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] value;
        logic       last;
    } sbt_result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Kind of a byte that stands alone outside an atom, K_NONE otherwise.
    function automatic logic [3:0] single_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LPAR:   k = K_LPAR;
            CH_RPAR:   k = K_RPAR;
            CH_DOT:    k = K_DOT;
            CH_QUOTE:  k = K_QUOTE;
            CH_BTICK:  k = K_QUASI;
            CH_COMMA:  k = K_UNQUOTE;
            CH_DOLLAR: k = K_SYM;
            CH_PCT:    k = K_NUM;
            CH_AT:     k = K_ATM;
            CH_QMARK:  k = K_EXP;
            CH_BANG:   k = K_HOT;
            default:   k = K_NONE;
        endcase
        return k;
    endfunction

    // Kind of a byte that closes an atom and then gives its own token.
    function automatic logic [3:0] term_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LPAR:  k = K_LPAR;
            CH_RPAR:  k = K_RPAR;
            CH_QUOTE: k = K_QUOTE;
            CH_BTICK: k = K_QUASI;
            CH_COMMA: k = K_UNQUOTE;
            default:  k = K_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- hdl/sexpr_byte_tokenizer_top.sv -----
// Channel  | Direction | tdata (low bit up) | tuser (low bit up) | tlast
// s_       | in        | ch[7:0]            | at_end[0]          | -
// m_       | out       | value[7:0]         | kind[3:0]          | last
//
// One byte transaction is taken per cycle; the tokenizer state is updated in the
// same cycle and the tokens it causes, none, one or two, are written to a four-entry
// result queue, which issues one token per cycle while m_tready is high. An
// input that gives two tokens issues them one after the other. s_tready is low
// while the queue holds over two entries: a stalled output backs up the input.
// Reset (aresetn low at a clock edge) empties the queue and leaves no atom open.
module sexpr_byte_tokenizer_top #(
    parameter int MAX_ATOM_LEN = sbt_pkg::MAX_ATOM_LEN_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch[7:0]
    input  logic [0:0] s_tuser,   // at_end[0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // value[7:0]
    output logic [3:0] m_tuser,   // kind[3:0]
    output logic       m_tlast
);
    import sbt_pkg::*;

    // The atom length counter only needs to reach the cap.
    localparam int LEN_W   = $clog2(MAX_ATOM_LEN + 1);
    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam logic [LEN_W:0] LEN_CAP = (LEN_W + 1)'(MAX_ATOM_LEN);

    // Tokenizer state
    logic             in_atom_reg, in_atom_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             fdig_reg, fdig_next;
    logic             fmin_reg, fmin_next;
    logic             sdig_reg, sdig_next;

    // Result queue
    sbt_result_t      q_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic        accept, pop;
    logic [7:0]  ch;
    logic        at_end;
    sbt_result_t res0, res1;
    logic [1:0]  push_n;

    logic [3:0]   s_kind, t_kind;
    logic [LEN_W:0] len_inc;
    logic         fdig_upd, fmin_upd, sdig_upd;
    logic         num_now, num_upd;

    assign ch     = s_tdata;
    assign at_end = s_tuser[0];
    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;

    // Room for the worst case of two tokens, whatever the byte turns out to be.
    assign s_tready = (count_reg <= CNT_W'(DEPTH - 2));

    assign s_kind  = single_kind(ch);
    assign t_kind  = term_kind(ch);
    assign len_inc = {1'b0, len_reg} + (LEN_W + 1)'(1);

    // Flags as they stand after this byte is taken into the atom.
    assign fdig_upd = (len_reg == '0) ? is_digit(ch) : fdig_reg;
    assign fmin_upd = (len_reg == '0) ? (ch == CH_MINUS) : fmin_reg;
    assign sdig_upd = (len_reg == LEN_W'(1)) ? is_digit(ch) : sdig_reg;
    assign num_now  = fdig_reg || (fmin_reg && sdig_reg);
    assign num_upd  = fdig_upd || (fmin_upd && sdig_upd);

    always_comb begin
        logic take;
        take         = 1'b0;
        in_atom_next = in_atom_reg;
        len_next     = len_reg;
        fdig_next    = fdig_reg;
        fmin_next    = fmin_reg;
        sdig_next    = sdig_reg;
        res0         = '{kind: K_NONE, value: 8'd0, last: 1'b0};
        res1         = '{kind: K_NONE, value: 8'd0, last: 1'b0};
        push_n       = 2'd0;

        if (at_end) begin
            if (in_atom_reg) begin
                res0.kind  = num_now ? K_NUMBER : K_SYMBOL;
                res0.value = 8'(len_reg);
                res1.kind  = K_EOF;
                push_n     = 2'd2;
            end else begin
                res0.kind = K_EOF;
                push_n    = 2'd1;
            end
            in_atom_next = 1'b0;
            len_next     = '0;
            fdig_next    = 1'b0;
            fmin_next    = 1'b0;
            sdig_next    = 1'b0;
        end else if (in_atom_reg) begin
            if (is_space(ch) || (t_kind != K_NONE)) begin
                res0.kind    = num_now ? K_NUMBER : K_SYMBOL;
                res0.value   = 8'(len_reg);
                res1.kind    = t_kind;
                push_n       = (t_kind != K_NONE) ? 2'd2 : 2'd1;
                in_atom_next = 1'b0;
                len_next     = '0;
                fdig_next    = 1'b0;
                fmin_next    = 1'b0;
                sdig_next    = 1'b0;
            end else begin
                take = 1'b1;
            end
        end else if (!is_space(ch)) begin
            if (s_kind != K_NONE) begin
                res0.kind = s_kind;
                push_n    = 2'd1;
            end else begin
                take = 1'b1;
            end
        end

        if (take) begin
            res0.kind  = K_BYTE;
            res0.value = ch;
            if (len_inc >= LEN_CAP) begin
                // The capping byte closes the atom straight away.
                res1.kind    = num_upd ? K_NUMBER : K_SYMBOL;
                res1.value   = 8'(len_inc);
                push_n       = 2'd2;
                in_atom_next = 1'b0;
                len_next     = '0;
                fdig_next    = 1'b0;
                fmin_next    = 1'b0;
                sdig_next    = 1'b0;
            end else begin
                push_n       = 2'd1;
                in_atom_next = 1'b1;
                len_next     = len_inc[LEN_W-1:0];
                fdig_next    = fdig_upd;
                fmin_next    = fmin_upd;
                sdig_next    = sdig_upd;
            end
        end

        if (push_n == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_atom_reg <= 1'b0;
            len_reg     <= '0;
            fdig_reg    <= 1'b0;
            fmin_reg    <= 1'b0;
            sdig_reg    <= 1'b0;
        end else if (accept) begin
            in_atom_reg <= in_atom_next;
            len_reg     <= len_next;
            fdig_reg    <= fdig_next;
            fmin_reg    <= fmin_next;
            sdig_reg    <= sdig_next;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge aclk) begin
        if (accept && (push_n != 2'd0)) begin
            q_mem[wr_ptr_reg] <= res0;
        end
        if (accept && (push_n == 2'd2)) begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (accept) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (accept ? CNT_W'(push_n) : CNT_W'(0))
                       - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_mem[rd_ptr_reg].value;
    assign m_tuser  = q_mem[rd_ptr_reg].kind;
    assign m_tlast  = q_mem[rd_ptr_reg].last;

    // The queue never overflows.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    // Outside an atom the length and flags are clear.
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_atom_reg |-> (len_reg == '0) && !fdig_reg && !fmin_reg && !sdig_reg)
        else $error("atom state not clear outside an atom");

    // An open atom stays below the length cap.
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        in_atom_reg |-> ({1'b0, len_reg} < LEN_CAP) && (len_reg != '0))
        else $error("atom length out of range");

    // End of input always leaves the tokenizer outside an atom.
    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && at_end) |=> !in_atom_reg)
        else $error("atom still open after end of input");

endmodule
